FILE: design/rwis_pkg.sv
// Shared types, codes and helpers for the ray/wall intersection sorter.
`default_nettype none
package rwis_pkg;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_CAST  = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  // 0.00001 in Q32.32
  localparam logic [66:0] DENOM_EPS = 67'd42950;

  typedef struct packed {
    logic [31:0] start_y;
    logic [31:0] start_x;
    logic [31:0] end_y;
    logic [31:0] end_x;
  } wall_t;

  typedef struct packed {
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [30:0] md;
  } ray_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] d2;
    logic [31:0] x;
    logic [31:0] y;
  } geom_res_t;

  typedef struct packed {
    logic [63:0] d2;
    logic [31:0] y;
    logic [31:0] x;
    logic [5:0]  idx;
  } hit_ent_t;

  typedef enum logic [3:0] {
    G_IDLE, G_MUL, G_NORM, G_TEST, G_PMUL, G_DCHK, G_DIV, G_OFF, G_SQ, G_CMP, G_FIN
  } geom_state_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RESP, S_WRD, S_WWAIT, S_GEOM, S_ICHK, S_ICMP, S_NEXT, S_ERD, S_EOUT
  } state_t;

  function automatic logic [31:0] sat32(input logic [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/ray_wall_intersection_sorter_core.sv
// Top level: wall table, cast sequencer, insertion sort of hits and result output.
//
//  channel | handshake          | payload
//  in      | in_valid/in_ready  | action, wall_*, ray_*, max_distance
//  out     | out_valid/out_ready| hit_valid, hit_x, hit_y, wall_index, table_full, last_result
//
// Clear, add and no-op requests pass through the response state, subject to output backpressure.
// A cast runs each stored wall through the geometry unit, which ends early for a parallel
// or missed wall; it uses a shared product sequence and, per axis, a 32-step scaling
// multiply and a 31-step divider. Each hit is inserted among the held ones, and each
// result is read from the hit RAM before it is emitted.
// Reset empties the wall table; the wall and hit RAMs need no clearing.
// A full output register stalls the sequencer; new requests wait in idle only.
`default_nettype none
module ray_wall_intersection_sorter_core
  import rwis_pkg::*;
#(
  parameter int MAX_WALLS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [31:0] wall_start_x,
  input  wire logic [31:0] wall_start_y,
  input  wire logic [31:0] wall_end_x,
  input  wire logic [31:0] wall_end_y,
  input  wire logic [31:0] ray_origin_x,
  input  wire logic [31:0] ray_origin_y,
  input  wire logic [31:0] ray_dir_x,
  input  wire logic [31:0] ray_dir_y,
  input  wire logic [30:0] max_distance,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             hit_valid,
  output logic [31:0]      hit_x,
  output logic [31:0]      hit_y,
  output logic [5:0]       wall_index,
  output logic             table_full,
  output logic             last_result
);
  localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int CW = $clog2(MAX_WALLS + 1);
  localparam logic [CW-1:0] CMAX = CW'(MAX_WALLS);

  state_t state, state_next;

  logic [CW-1:0] wall_count, wi, n, j, e;
  logic          resp_full;
  logic [5:0]    resp_idx;
  ray_t          ray;
  hit_ent_t      new_ent, rd_ent, h_wdata;
  logic          h_wen;
  logic [AW-1:0] h_waddr, h_raddr;
  wall_t         wall_rd, wall_wr;
  logic          w_wen;
  logic          accept, out_free, load_resp, load_hit, g_done;
  geom_res_t     g_res;
  logic [CW-1:0] wi_inc, e_inc, j_dec;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign wi_inc   = CW'(wi + 1'b1);
  assign e_inc    = CW'(e + 1'b1);
  assign j_dec    = CW'(j - 1'b1);
  assign wall_wr  = '{start_y: wall_start_y, start_x: wall_start_x,
                      end_y: wall_end_y, end_x: wall_end_x};
  assign w_wen    = accept && action == ACT_ADD && wall_count != CMAX;

  rwis_ram #(.WIDTH($bits(wall_t)), .DEPTH(MAX_WALLS)) u_wall_ram (
    .clk(clk), .wen(w_wen), .waddr(wall_count[AW-1:0]), .wdata(wall_wr),
    .raddr(wi[AW-1:0]), .rdata(wall_rd)
  );

  rwis_ram #(.WIDTH($bits(hit_ent_t)), .DEPTH(MAX_WALLS)) u_hit_ram (
    .clk(clk), .wen(h_wen), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(rd_ent)
  );

  rwis_geom u_geom (
    .clk(clk), .rst(rst), .start(state == S_WWAIT), .wall(wall_rd), .ray(ray),
    .done(g_done), .res(g_res)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = (action == ACT_CAST && wall_count != '0) ? S_WRD : S_RESP;
      S_RESP:  if (out_free) state_next = S_IDLE;
      S_WRD:   state_next = S_WWAIT;
      S_WWAIT: state_next = S_GEOM;
      S_GEOM:  if (g_done) state_next = g_res.hit ? S_ICHK : S_NEXT;
      S_ICHK:  state_next = (j == '0) ? S_NEXT : S_ICMP;
      S_ICMP:  state_next = (rd_ent.d2 < new_ent.d2) ? S_ICHK : S_NEXT;
      S_NEXT:  if (wi_inc == wall_count) state_next = (n == '0) ? S_RESP : S_ERD;
               else state_next = S_WRD;
      S_ERD:   state_next = S_EOUT;
      S_EOUT:  if (out_free) state_next = (e_inc == n) ? S_IDLE : S_ERD;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    load_resp = (state == S_RESP) && out_free;
    load_hit  = (state == S_EOUT) && out_free;
    h_raddr   = (state == S_ICHK) ? j_dec[AW-1:0] : e[AW-1:0];
    h_wen     = 1'b0;
    h_waddr   = j[AW-1:0];
    h_wdata   = new_ent;
    if (state == S_ICHK && j == '0) h_wen = 1'b1;
    if (state == S_ICMP) begin
      h_wen = 1'b1;
      // shift the nearer entry down one slot
      if (rd_ent.d2 < new_ent.d2) h_wdata = rd_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_count <= '0;
    end else if (accept) begin
      if (action == ACT_CLEAR) wall_count <= '0;
      else if (w_wen)          wall_count <= CW'(wall_count + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      resp_full <= action == ACT_ADD && wall_count == CMAX;
      resp_idx  <= w_wen ? 6'(wall_count) : 6'd0;
      ray       <= '{ox: ray_origin_x, oy: ray_origin_y, dx: ray_dir_x, dy: ray_dir_y,
                     md: max_distance};
      wi        <= '0;
      n         <= '0;
      e         <= '0;
    end
    if (state == S_GEOM && g_done) begin
      new_ent <= '{d2: g_res.d2, y: g_res.y, x: g_res.x, idx: 6'(wi)};
      j       <= n;
    end
    if (state == S_ICHK && j == '0) n <= CW'(n + 1'b1);
    if (state == S_ICMP) begin
      if (rd_ent.d2 < new_ent.d2) j <= j_dec;
      else                        n <= CW'(n + 1'b1);
    end
    if (state == S_NEXT) wi <= wi_inc;
    if (load_hit) e <= e_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_resp || load_hit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_resp) begin
      hit_valid   <= 1'b0;
      hit_x       <= '0;
      hit_y       <= '0;
      wall_index  <= resp_idx;
      table_full  <= resp_full;
      last_result <= 1'b1;
    end else if (load_hit) begin
      hit_valid   <= 1'b1;
      hit_x       <= rd_ent.x;
      hit_y       <= rd_ent.y;
      wall_index  <= rd_ent.idx;
      table_full  <= 1'b0;
      last_result <= (e_inc == n);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    wall_count <= CMAX) else $error("wall count beyond table size");

  a_nohit_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit_valid |-> last_result) else $error("non-hit result not last");

  a_full_nohit: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !hit_valid) else $error("table full flagged on a hit");

  a_geom_done: assert property (@(posedge clk) disable iff (rst)
    g_done |-> state == S_GEOM) else $error("geometry done outside cast walk");
endmodule
`default_nettype wire

FILE: design/rwis_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rwis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wen,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: design/rwis_geom.sv
// Per-wall intersection unit: shared multiplier, serial scaling multiply and divider.
`default_nettype none
module rwis_geom
  import rwis_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire wall_t     wall,
  input  wire ray_t      ray,
  output logic           done,
  output geom_res_t      res
);
  geom_state_t state, state_next;

  logic [4:0]  cnt;
  logic signed [32:0] s2x, s2y, ex, ey;
  logic [66:0] den, sn, tn;
  logic [61:0] md2;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic [66:0] prod_x;
  logic        axis;
  logic [31:0] dsh;
  logic [97:0] nacc;
  logic [66:0] rem;
  logic [30:0] nlow;
  logic [30:0] q;
  logic [31:0] offx, offy;
  logic [30:0] mx, my;
  logic [63:0] d2;
  logic        skip, far, dneg;
  logic [67:0] dtry, dsub;
  logic [31:0] dxm, dym;

  assign prod_x = {prod[65], prod};
  assign skip = (den < DENOM_EPS) || sn[66] || (sn > den) || tn[66];
  assign far  = nacc >= {1'b0, den[65:0], 31'b0};
  assign dneg = axis ? ray.dy[31] : ray.dx[31];
  assign dxm  = ray.dx[31] ? 32'(-ray.dx) : ray.dx;
  assign dym  = ray.dy[31] ? 32'(-ray.dy) : ray.dy;
  assign dtry = {rem, nlow[30]};
  assign dsub = dtry - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) state <= G_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      G_IDLE: if (start) state_next = G_MUL;
      G_MUL:  if (cnt == 5'd7) state_next = G_NORM;
      G_NORM: state_next = G_TEST;
      G_TEST: state_next = skip ? G_FIN : G_PMUL;
      G_PMUL: if (cnt == 5'd31) state_next = G_DCHK;
      G_DCHK: state_next = far ? G_FIN : G_DIV;
      G_DIV:  if (cnt == 5'd30) state_next = G_OFF;
      G_OFF:  state_next = axis ? G_SQ : G_PMUL;
      G_SQ:   if (cnt == 5'd2) state_next = G_CMP;
      G_CMP:  state_next = G_FIN;
      G_FIN:  state_next = G_IDLE;
      default: state_next = G_IDLE;
    endcase
  end

  always_comb begin
    done  = (state == G_FIN);
    mul_a = '0;
    mul_b = '0;
    if (state == G_MUL) begin
      case (cnt)
        5'd0: begin mul_a = $signed({ray.dx[31], ray.dx}); mul_b = s2y; end
        5'd1: begin mul_a = $signed({ray.dy[31], ray.dy}); mul_b = s2x; end
        5'd2: begin mul_a = $signed({ray.dx[31], ray.dx}); mul_b = ey;  end
        5'd3: begin mul_a = $signed({ray.dy[31], ray.dy}); mul_b = ex;  end
        5'd4: begin mul_a = s2x; mul_b = ey; end
        5'd5: begin mul_a = s2y; mul_b = ex; end
        5'd6: begin mul_a = $signed({2'b0, ray.md}); mul_b = $signed({2'b0, ray.md}); end
        default: ;
      endcase
    end else if (state == G_SQ) begin
      case (cnt)
        5'd0: begin mul_a = $signed({2'b0, mx}); mul_b = $signed({2'b0, mx}); end
        5'd1: begin mul_a = $signed({2'b0, my}); mul_b = $signed({2'b0, my}); end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || state_next != state) cnt <= '0;
    else                            cnt <= cnt + 5'd1;
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      G_IDLE: if (start) begin
        s2x <= $signed({wall.end_x[31], wall.end_x}) - $signed({wall.start_x[31], wall.start_x});
        s2y <= $signed({wall.end_y[31], wall.end_y}) - $signed({wall.start_y[31], wall.start_y});
        ex  <= $signed({ray.ox[31], ray.ox}) - $signed({wall.start_x[31], wall.start_x});
        ey  <= $signed({ray.oy[31], ray.oy}) - $signed({wall.start_y[31], wall.start_y});
      end
      G_MUL: begin
        // product of the previous cycle lands here
        case (cnt)
          5'd1: den <= prod_x;
          5'd2: den <= den - prod_x;
          5'd3: sn  <= prod_x;
          5'd4: sn  <= sn - prod_x;
          5'd5: tn  <= prod_x;
          5'd6: tn  <= tn - prod_x;
          5'd7: md2 <= prod[61:0];
          default: ;
        endcase
      end
      G_NORM: if (den[66]) begin
        den <= 67'(-den);
        sn  <= 67'(-sn);
        tn  <= 67'(-tn);
      end
      G_TEST: begin
        res.hit <= 1'b0;
        axis    <= 1'b0;
        dsh     <= dxm;
        nacc    <= '0;
      end
      G_PMUL: begin
        nacc <= {nacc[96:0], 1'b0} + (dsh[31] ? {31'b0, tn} : 98'd0);
        dsh  <= {dsh[30:0], 1'b0};
      end
      G_DCHK: begin
        rem  <= nacc[97:31];
        nlow <= nacc[30:0];
        q    <= '0;
      end
      G_DIV: begin
        if (!dsub[67]) begin
          rem <= dsub[66:0];
          q   <= {q[29:0], 1'b1};
        end else begin
          rem <= dtry[66:0];
          q   <= {q[29:0], 1'b0};
        end
        nlow <= {nlow[29:0], 1'b0};
      end
      G_OFF: begin
        if (axis) begin
          offy <= dneg ? 32'(-{1'b0, q}) : {1'b0, q};
          my   <= q;
        end else begin
          offx <= dneg ? 32'(-{1'b0, q}) : {1'b0, q};
          mx   <= q;
          axis <= 1'b1;
          dsh  <= dym;
          nacc <= '0;
        end
      end
      G_SQ: begin
        if (cnt == 5'd1) d2 <= prod[63:0];
        if (cnt == 5'd2) d2 <= d2 + prod[63:0];
      end
      G_CMP: begin
        res.hit <= d2 <= {2'b0, md2};
        res.d2  <= d2;
        res.x   <= sat32({ray.ox[31], ray.ox} + {offx[31], offx});
        res.y   <= sat32({ray.oy[31], ray.oy} + {offy[31], offy});
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
